### hdl/dcr_pkg.sv
// Shared constants, types and colour ramp function for the depth colour ramp.
`timescale 1ns / 1ps
package dcr_pkg;

	localparam int DEPTH_BITS = 24;
	localparam int TABLE_SIZE = 2048;
	localparam int TBITS      = $clog2(TABLE_SIZE);

	localparam int NEAR_W    = 16;
	localparam int FAR_W     = 16;
	localparam int OFF_W     = 12;
	localparam int SCALE_W   = 20;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NEAR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd3;

	localparam logic [NEAR_W-1:0]  NEAR_RST  = 16'd700;
	localparam logic [FAR_W-1:0]   FAR_RST   = 16'd20000;
	localparam logic [OFF_W-1:0]   OFF_RST   = 12'd1090;
	localparam logic [SCALE_W-1:0] SCALE_RST = 20'd348000;

	localparam int NUM_W    = FAR_W + DEPTH_BITS;
	localparam int NUM_LO_W = NUM_W / 2;
	localparam int NUM_HI_W = NUM_W - NUM_LO_W;
	localparam int PLO_W    = SCALE_W + NUM_LO_W;
	localparam int PHI_W    = SCALE_W + NUM_HI_W;
	localparam int PROD_W   = SCALE_W + NUM_W;
	localparam int DIVD_W   = PROD_W - DEPTH_BITS;
	localparam int FN_W     = NEAR_W + FAR_W;
	localparam int QBITS    = OFF_W;
	localparam int CMP_W    = FN_W + QBITS;
	localparam int DIV_LAT  = QBITS + 1;
	localparam int PIPE_LAT = DIV_LAT + 9;

	localparam int ROM_W     = 14;
	localparam int SEG_W     = ROM_W - 8;
	localparam int SQ_W      = 2 * TBITS;
	localparam int CU_W      = 3 * TBITS;
	localparam int GAIN_W    = CU_W + 4;
	localparam int ROM_SHIFT = 3 * TBITS - 10;

	localparam logic [SEG_W-1:0] SEG_WHITE_RED    = 6'd0;
	localparam logic [SEG_W-1:0] SEG_RED_YELLOW   = 6'd1;
	localparam logic [SEG_W-1:0] SEG_YELLOW_GREEN = 6'd2;
	localparam logic [SEG_W-1:0] SEG_GREEN_CYAN   = 6'd3;
	localparam logic [SEG_W-1:0] SEG_CYAN_BLUE    = 6'd4;
	localparam logic [SEG_W-1:0] SEG_BLUE_BLACK   = 6'd5;

	typedef struct packed {
		logic last;
		logic frac_nz;
	} dcr_tag_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} dcr_rgb_t;

	function automatic dcr_rgb_t dcr_color(input logic [ROM_W-1:0] pval);
		dcr_rgb_t   c;
		logic [7:0] lb;
		lb = pval[7:0];
		c  = '0;
		case (pval[ROM_W-1:8])
			SEG_WHITE_RED: begin
				c.r = 8'hFF;      c.g = 8'hFF - lb; c.b = 8'hFF - lb;
			end
			SEG_RED_YELLOW: begin
				c.r = 8'hFF;      c.g = lb;         c.b = 8'h00;
			end
			SEG_YELLOW_GREEN: begin
				c.r = 8'hFF - lb; c.g = 8'hFF;      c.b = 8'h00;
			end
			SEG_GREEN_CYAN: begin
				c.r = 8'h00;      c.g = 8'hFF;      c.b = lb;
			end
			SEG_CYAN_BLUE: begin
				c.r = 8'h00;      c.g = 8'hFF - lb; c.b = 8'hFF;
			end
			SEG_BLUE_BLACK: begin
				c.r = 8'h00;      c.g = 8'h00;      c.b = 8'hFF - lb;
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

### hdl/dcr_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
`timescale 1ns / 1ps
module dcr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  dcr_pkg::dcr_tag_t           in_tag,
	input  logic [dcr_pkg::DIVD_W-1:0]  dividend,
	input  logic [dcr_pkg::FN_W-1:0]    divisor,
	output logic                        out_valid,
	output dcr_pkg::dcr_tag_t           out_tag,
	output logic                        out_ovf,
	output logic [dcr_pkg::QBITS-1:0]   out_quot,
	output logic                        out_rem_nz
);
	import dcr_pkg::*;

	logic [QBITS:0]        v_s;
	logic [DIVD_W-1:0]     rem_s  [QBITS+1];
	logic [QBITS-1:0]      quot_s [QBITS+1];
	logic                  ovf_s  [QBITS+1];
	dcr_tag_t              tag_s  [QBITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[QBITS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= dividend;
		quot_s[0] <= '0;
		ovf_s[0]  <= CMP_W'(dividend) >= {divisor, {QBITS{1'b0}}};
		tag_s[0]  <= in_tag;
	end

	for (genvar j = 1; j <= QBITS; j++) begin : g_step
		localparam int K = QBITS - j;
		logic [CMP_W-1:0] trial;
		logic [CMP_W-1:0] diff;
		logic             ge;
		logic [QBITS-1:0] qbit;

		assign trial = CMP_W'(divisor) << K;
		assign ge    = CMP_W'(rem_s[j-1]) >= trial;
		assign diff  = CMP_W'(rem_s[j-1]) - trial;
		assign qbit  = QBITS'(ge) << K;

		always_ff @(posedge clk) begin
			rem_s[j]  <= ge ? diff[DIVD_W-1:0] : rem_s[j-1];
			quot_s[j] <= quot_s[j-1] | qbit;
			ovf_s[j]  <= ovf_s[j-1];
			tag_s[j]  <= tag_s[j-1];
		end
	end

	assign out_valid  = v_s[QBITS];
	assign out_tag    = tag_s[QBITS];
	assign out_ovf    = ovf_s[QBITS];
	assign out_quot   = quot_s[QBITS];
	assign out_rem_nz = |rem_s[QBITS];

endmodule

### hdl/depth_to_color_ramp.sv
// Top level: depth sample to disparity, cube-law gamma and six-segment colour ramp.
`timescale 1ns / 1ps
// One pixel is taken on every clock: busy stays low and start alone marks a beat. Each
// result appears on red, green, blue and frame_end with done high for one cycle; results
// leave in input order and cannot be held off. The pipeline holds the 13-stage divider (an
// overflow check and one quotient bit per stage) that forms scale over depth, plus four
// stages of depth and product arithmetic ahead of it and five stages of clamp, cube and
// colour behind it. The user must write registers through cfg_we, cfg_index and cfg_data
// only while no pixel is in flight; the block itself does not enforce this.
module depth_to_color_ramp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [dcr_pkg::DEPTH_BITS-1:0]  depth_sample,
	input  logic                            last_in_frame,
	input  logic                            cfg_we,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dcr_pkg::CFG_W-1:0]       cfg_data,
	output logic                            done,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic                            frame_end
);
	import dcr_pkg::*;

	logic [NEAR_W-1:0]   near_q;
	logic [FAR_W-1:0]    far_q;
	logic [OFF_W-1:0]    off_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [FN_W-1:0]     fn_q;

	logic                acc;
	logic [DEPTH_BITS:0] rest;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                last_s1, last_s2, last_s3, last_s4;
	logic [NUM_W-1:0]    fd_s1, nd_s1;
	logic [NUM_W-1:0]    num_s2;
	logic [PLO_W-1:0]    plo_s3;
	logic [PHI_W-1:0]    phi_s3;
	logic [PROD_W-1:0]   prod;
	logic [DIVD_W-1:0]   ph_s4;
	logic                fnz_s4;
	dcr_tag_t            tag_s4;

	logic                div_valid;
	dcr_tag_t            div_tag;
	logic                div_ovf;
	logic [QBITS-1:0]    div_quot;
	logic                div_rem_nz;

	logic [QBITS:0]      q_ceil;
	logic [QBITS:0]      gap;
	logic [QBITS-1:0]    kd_wide;
	logic [QBITS-1:0]    kd_clamp;
	logic                plane_zero;

	logic                v_s18, v_s19, v_s20, v_s21, v_s22;
	logic                last_s18, last_s19, last_s20, last_s21, last_s22;
	logic [TBITS-1:0]    kd_s18, kd_s19;
	logic [SQ_W-1:0]     sq_s19;
	logic [CU_W-1:0]     cu_s20;
	logic [GAIN_W-1:0]   gain;
	logic [ROM_W-1:0]    pval_s21;
	dcr_rgb_t            rgb_s22;

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q  <= NEAR_RST;
			far_q   <= FAR_RST;
			off_q   <= OFF_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEAR:  near_q  <= cfg_data[NEAR_W-1:0];
				REG_FAR:   far_q   <= cfg_data[FAR_W-1:0];
				REG_OFF:   off_q   <= cfg_data[OFF_W-1:0];
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		fn_q <= FN_W'(near_q) * FN_W'(far_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
		end else begin
			v_s1  <= acc;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s18 <= div_valid;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
			v_s21 <= v_s20;
			v_s22 <= v_s21;
		end
	end

	assign rest = {1'b1, {DEPTH_BITS{1'b0}}} - {1'b0, depth_sample};
	assign prod = PROD_W'(plo_s3) + (PROD_W'(phi_s3) << NUM_LO_W);

	always_ff @(posedge clk) begin
		fd_s1   <= NUM_W'(far_q) * NUM_W'(rest);
		nd_s1   <= NUM_W'(near_q) * NUM_W'(depth_sample);
		last_s1 <= last_in_frame;

		num_s2  <= fd_s1 + nd_s1;
		last_s2 <= last_s1;

		plo_s3  <= PLO_W'(scale_q) * PLO_W'(num_s2[NUM_LO_W-1:0]);
		phi_s3  <= PHI_W'(scale_q) * PHI_W'(num_s2[NUM_W-1:NUM_LO_W]);
		last_s3 <= last_s2;

		ph_s4   <= prod[PROD_W-1:DEPTH_BITS];
		fnz_s4  <= |prod[DEPTH_BITS-1:0];
		last_s4 <= last_s3;
	end

	assign tag_s4.last    = last_s4;
	assign tag_s4.frac_nz = fnz_s4;

	dcr_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s4),
		.in_tag     (tag_s4),
		.dividend   (ph_s4),
		.divisor    (fn_q),
		.out_valid  (div_valid),
		.out_tag    (div_tag),
		.out_ovf    (div_ovf),
		.out_quot   (div_quot),
		.out_rem_nz (div_rem_nz)
	);

	always_comb begin
		plane_zero = (near_q == '0) || (far_q == '0);
		if (div_ovf) begin
			q_ceil = {1'b1, {QBITS{1'b0}}};
		end else begin
			q_ceil = {1'b0, div_quot} + (QBITS+1)'(div_rem_nz | div_tag.frac_nz);
		end
		gap      = {1'b0, off_q} - q_ceil;
		kd_wide  = ({1'b0, off_q} > q_ceil) ? gap[QBITS-1:0] : '0;
		kd_clamp = (kd_wide > QBITS'(TABLE_SIZE - 1)) ? QBITS'(TABLE_SIZE - 1) : kd_wide;
	end

	assign gain = (GAIN_W'(cu_s20) << 3) + GAIN_W'(cu_s20);

	always_ff @(posedge clk) begin
		kd_s18   <= plane_zero ? '0 : kd_clamp[TBITS-1:0];
		last_s18 <= div_tag.last;

		sq_s19   <= SQ_W'(kd_s18) * SQ_W'(kd_s18);
		kd_s19   <= kd_s18;
		last_s19 <= last_s18;

		cu_s20   <= CU_W'(sq_s19) * CU_W'(kd_s19);
		last_s20 <= last_s19;

		pval_s21 <= ROM_W'(gain >> ROM_SHIFT);
		last_s21 <= last_s20;

		rgb_s22  <= dcr_color(pval_s21);
		last_s22 <= last_s21;
	end

	assign done      = v_s22;
	assign red       = rgb_s22.r;
	assign green     = rgb_s22.g;
	assign blue      = rgb_s22.b;
	assign frame_end = last_s22;

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##PIPE_LAT done)
		else $error("accepted beat did not produce a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, PIPE_LAT))
		else $error("result without a matching accepted beat");

	a_ramp_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red == 8'hFF) || (red == 8'h00) || (blue == 8'h00))
		else $error("colour off the ramp");

endmodule
